// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define RDHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication: whenever ante holds, cons holds.
`define RDHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define RDHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rdht_pkg.sv =====
// Shared constants, slot entry layout and controller/datapath interface types
// for the record dedup hash table. No dependencies.
package rdht_pkg;

    // Slot count must be a power of two: home slot and wrap use the low hash bits.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int SLOT_OUT_W  = 10;
    localparam int ORD_W       = 16;
    localparam int TARGET_W    = 25;
    localparam int TIMES_W     = 64;
    localparam int TAG_W       = 8;
    localparam int KEY_BYTES   = 12;
    localparam int BYTE_CNT_W  = $clog2(KEY_BYTES);

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    // Epoch tags: a slot is live only when its tag equals the current epoch.
    localparam logic [TAG_W-1:0] TAG_CLEAR = '0;
    localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_LAST  = '1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } result_code_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [TARGET_W-1:0] target;
        logic [TIMES_W-1:0]  times;
        logic [ORD_W-1:0]    ordinal;
    } slot_entry_t;

    typedef struct packed {
        logic load;
        logic wipe_start;
        logic wipe_step;
        logic hash_step;
        logic probe_read;
        logic probe_check;
        logic emit;
    } rdht_cmd_t;

    typedef struct packed {
        logic wrap_on_load;
        logic wipe_last;
        logic hash_last;
        logic slot_empty;
        logic slot_match;
        logic sweep_last;
        logic out_free;
    } rdht_stat_t;

endpackage

// ===== hw/rtl/rdht_datapath.sv =====
// Datapath: key capture, byte-serial FNV-1a hash, slot memory with epoch tags,
// linear probe compare and the output register. Depends on rdht_pkg.
module rdht_datapath
    import rdht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rdht_cmd_t             cmd,
    output rdht_stat_t            stat,
    input  logic                  start_of_set,
    input  logic [7:0]            target_device,
    input  logic [7:0]            target_pin,
    input  logic [7:0]            operation_code,
    input  logic                  level_value,
    input  logic [31:0]           delay_ms,
    input  logic [31:0]           duration_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [SLOT_OUT_W-1:0] slot_index,
    output logic [ORD_W-1:0]      earlier_ordinal
);

    // key capture
    logic [TARGET_W-1:0] target_reg;
    logic [TIMES_W-1:0]  times_reg;

    // ordinals and epoch
    logic [ORD_W-1:0]    ord_cnt_reg;
    logic [ORD_W-1:0]    cur_ord_reg;
    logic [TAG_W-1:0]    epoch_reg;
    logic [SLOT_W-1:0]   wipe_cnt_reg;

    // hash
    logic [31:0]           h_reg;
    logic [31:0]           h_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg;
    logic [8*KEY_BYTES-1:0] key_bytes;
    logic [7:0]            key_byte;

    // probe
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   probe_cnt_reg;
    slot_entry_t         mem [TABLE_SLOTS];
    slot_entry_t         rd_reg;
    slot_entry_t         wr_data;
    logic [SLOT_W-1:0]   wr_addr;
    logic                wr_en;
    logic                slot_empty;
    logic                slot_match;

    // result
    result_code_t        res_code_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [ORD_W-1:0]    res_ord_reg;
    logic [SLOT_W+SLOT_OUT_W-1:0] res_slot_wide;

    logic                out_valid_reg;
    result_code_t        out_code_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [ORD_W-1:0]    out_ord_reg;

    assign key_bytes = {times_reg[63:32], times_reg[31:0],
                        7'b0, target_reg[24], target_reg[23:16],
                        target_reg[15:8], target_reg[7:0]};
    assign key_byte  = key_bytes[byte_cnt_reg*8 +: 8];
    assign h_next    = 32'((h_reg ^ {24'b0, key_byte}) * FNV_PRIME);

    assign slot_empty = (rd_reg.tag != epoch_reg);
    assign slot_match = !slot_empty && (rd_reg.target == target_reg)
                        && (rd_reg.times == times_reg);

    assign stat.wrap_on_load = start_of_set && (epoch_reg == TAG_LAST);
    assign stat.wipe_last    = (wipe_cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign stat.hash_last    = (byte_cnt_reg == BYTE_CNT_W'(KEY_BYTES - 1));
    assign stat.slot_empty   = slot_empty;
    assign stat.slot_match   = slot_match;
    assign stat.sweep_last   = (probe_cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign stat.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_en   = cmd.wipe_step || (cmd.probe_check && slot_empty);
        wr_addr = cmd.wipe_step ? wipe_cnt_reg : slot_reg;
        if (cmd.wipe_step)
        begin
            wr_data.tag     = TAG_CLEAR;
            wr_data.target  = '0;
            wr_data.times   = '0;
            wr_data.ordinal = '0;
        end
        else
        begin
            wr_data.tag     = epoch_reg;
            wr_data.target  = target_reg;
            wr_data.times   = times_reg;
            wr_data.ordinal = cur_ord_reg;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.probe_read)
        begin
            rd_reg <= mem[slot_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            target_reg <= {level_value, operation_code, target_pin, target_device};
            times_reg  <= {duration_ms, delay_ms};
        end
        if (cmd.hash_step && stat.hash_last)
        begin
            slot_reg <= h_next[SLOT_W-1:0];
        end
        else if (cmd.probe_check && !slot_empty && !slot_match)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
        if (cmd.probe_check)
        begin
            if (slot_empty)
            begin
                res_code_reg <= ST_INSERTED;
                res_slot_reg <= slot_reg;
                res_ord_reg  <= '0;
            end
            else if (slot_match)
            begin
                res_code_reg <= ST_DUPLICATE;
                res_slot_reg <= slot_reg;
                res_ord_reg  <= rd_reg.ordinal;
            end
            else
            begin
                res_code_reg <= ST_FULL;
                res_slot_reg <= '0;
                res_ord_reg  <= '0;
            end
        end
        if (cmd.emit)
        begin
            out_code_reg <= res_code_reg;
            out_slot_reg <= res_slot_wide[SLOT_OUT_W-1:0];
            out_ord_reg  <= res_ord_reg;
        end
    end

    assign res_slot_wide = {{SLOT_OUT_W{1'b0}}, res_slot_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ord_cnt_reg   <= '0;
            cur_ord_reg   <= '0;
            epoch_reg     <= TAG_FIRST;
            wipe_cnt_reg  <= '0;
            h_reg         <= FNV_OFFSET;
            byte_cnt_reg  <= '0;
            probe_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (start_of_set)
                begin
                    cur_ord_reg <= '0;
                    ord_cnt_reg <= ORD_W'(1);
                end
                else
                begin
                    cur_ord_reg <= ord_cnt_reg;
                    ord_cnt_reg <= ord_cnt_reg + ORD_W'(1);
                end
                h_reg        <= FNV_OFFSET;
                byte_cnt_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                h_reg        <= h_next;
                byte_cnt_reg <= byte_cnt_reg + BYTE_CNT_W'(1);
            end

            // epoch wrap forces a full clear and restarts the tag sequence
            if (cmd.wipe_start)
            begin
                epoch_reg    <= TAG_FIRST;
                wipe_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.load && start_of_set)
                begin
                    epoch_reg <= epoch_reg + TAG_W'(1);
                end
                if (cmd.wipe_step)
                begin
                    wipe_cnt_reg <= wipe_cnt_reg + SLOT_W'(1);
                end
            end

            if (cmd.hash_step && stat.hash_last)
            begin
                probe_cnt_reg <= '0;
            end
            else if (cmd.probe_check && !slot_empty && !slot_match)
            begin
                probe_cnt_reg <= probe_cnt_reg + SLOT_W'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_code_reg;
    assign slot_index      = out_slot_reg;
    assign earlier_ordinal = out_ord_reg;

endmodule

// ===== hw/rtl/rdht_ctrl.sv =====
// Controller state machine: table clear sweep, hash sequencing, probe loop
// and result hand-off. Depends on rdht_pkg.
module rdht_ctrl
    import rdht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rdht_stat_t stat,
    output rdht_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   pending_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_WIPE:
            begin
                cmd.wipe_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.load       = in_valid;
                cmd.wipe_start = in_valid && stat.wrap_on_load;
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
            end
            S_READ:
            begin
                cmd.probe_read = 1'b1;
            end
            S_CHECK:
            begin
                cmd.probe_check = 1'b1;
            end
            S_FINISH:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_WIPE;
            pending_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_WIPE:
                begin
                    if (stat.wipe_last)
                    begin
                        state_reg   <= pending_reg ? S_HASH : S_IDLE;
                        pending_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (stat.wrap_on_load)
                        begin
                            state_reg   <= S_WIPE;
                            pending_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    if (stat.hash_last)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (stat.slot_empty || stat.slot_match || stat.sweep_last)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_FINISH:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/record_dedup_hash_table_core.sv =====
// Record dedup hash table. Each item is one action definition; its twelve key
// bytes are hashed with 32-bit FNV-1a one byte per cycle, the low hash bits
// give the home slot, and the table is probed linearly through a slot memory
// with one write and one registered read port (each probe reads, then
// compares). An item probes at least one slot and at most TABLE_SLOTS. The
// result sits in an output register, so the next item can be taken while it
// waits. After reset, and on every 255th start-of-set item, a clearing pass
// sweeps the epoch tags of all TABLE_SLOTS (1024) slots; no item is accepted
// during the post-reset pass.
// Depends on rdht_pkg, rdht_ctrl and rdht_datapath.
module record_dedup_hash_table_core
    import rdht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_of_set,
    input  logic [7:0]            target_device,
    input  logic [7:0]            target_pin,
    input  logic [7:0]            operation_code,
    input  logic                  level_value,
    input  logic [31:0]           delay_ms,
    input  logic [31:0]           duration_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [SLOT_OUT_W-1:0] slot_index,
    output logic [ORD_W-1:0]      earlier_ordinal
);

    rdht_cmd_t  cmd;
    rdht_stat_t stat;

    rdht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdht_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .start_of_set    (start_of_set),
        .target_device   (target_device),
        .target_pin      (target_pin),
        .operation_code  (operation_code),
        .level_value     (level_value),
        .delay_ms        (delay_ms),
        .duration_ms     (duration_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_index      (slot_index),
        .earlier_ordinal (earlier_ordinal)
    );

endmodule

// ===== hw/rtl/rdht_checker.sv =====
// Port-level checker for record_dedup_hash_table_core, attached by bind.
// Depends on rdht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rdht_checker
    import rdht_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            status,
    input logic [SLOT_OUT_W-1:0] slot_index,
    input logic [ORD_W-1:0]      earlier_ordinal
);

    // a stalled result holds
    `RDHT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_index) && $stable(earlier_ordinal), "stalled result changed")

    `RDHT_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status == ST_INSERTED || status == ST_DUPLICATE || status == ST_FULL, "undefined status code")

    `RDHT_ASSERT_IMP(a_full_zero, clk, rst_n, out_valid && status == ST_FULL, slot_index == '0 && earlier_ordinal == '0, "table full result carries nonzero fields")

    `RDHT_ASSERT_IMP(a_insert_ord, clk, rst_n, out_valid && status == ST_INSERTED, earlier_ordinal == '0, "insert reports an earlier ordinal")

    // one item at a time: no back-to-back acceptance
    `RDHT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while busy")

endmodule

bind record_dedup_hash_table_core rdht_checker u_rdht_checker (.*);
